### rtl/rip_pkg.sv
// Shared types and constants for the radix integer parser.
package rip_pkg;

    localparam logic [7:0] CHAR_HASH    = 8'h23;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;
    localparam logic [7:0] HEX_LETTER_BASE = 8'd10;

    localparam logic [4:0] DIGIT_NONE = 5'd16;

    typedef enum logic [1:0] {
        RADIX_BIN = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_DEC = 2'd2,
        RADIX_HEX = 2'd3
    } t_radix;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_PREFIX = 2'd1,
        ST_NO_DIGITS = 2'd2,
        ST_BAD_DIGIT = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } t_char_item;

    typedef struct packed {
        logic [63:0] parsed_value;
        logic [1:0]  status;
    } t_result;

    typedef struct packed {
        logic [4:0] digit;
        logic       is_hash;
        logic       is_last;
    } t_token;

endpackage

### rtl/rip_fifo.sv
// Small register-based queue used between pipeline parts.
module rip_fifo #(
    parameter int WIDTH     = 8,
    parameter int ADDR_BITS = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [WIDTH-1:0]   r_mem [DEPTH];
    logic [ADDR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [ADDR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [ADDR_BITS:0]   r_count, n_count;
    logic do_push, do_pop;

    assign o_full  = (r_count == (ADDR_BITS + 1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### rtl/rip_front.sv
// Front end: accepts characters and classifies them into tokens.
module rip_front (
    input  logic                i_push,
    input  rip_pkg::t_char_item i_item,
    input  logic                i_tok_full,
    output logic                o_tok_push,
    output rip_pkg::t_token     o_token
);

    logic [7:0] c;

    assign c          = i_item.char_code;
    assign o_tok_push = i_push && !i_tok_full;

    always_comb begin
        o_token.is_hash = (c == rip_pkg::CHAR_HASH);
        o_token.is_last = i_item.is_last;
        priority if (c >= rip_pkg::CHAR_ZERO && c <= rip_pkg::CHAR_NINE) begin
            o_token.digit = 5'(c - rip_pkg::CHAR_ZERO);
        end else if (c >= rip_pkg::CHAR_UPPER_A && c <= rip_pkg::CHAR_UPPER_F) begin
            o_token.digit = 5'(c - rip_pkg::CHAR_UPPER_A + rip_pkg::HEX_LETTER_BASE);
        end else if (c >= rip_pkg::CHAR_LOWER_A && c <= rip_pkg::CHAR_LOWER_F) begin
            o_token.digit = 5'(c - rip_pkg::CHAR_LOWER_A + rip_pkg::HEX_LETTER_BASE);
        end else begin
            o_token.digit = rip_pkg::DIGIT_NONE;
        end
    end

endmodule

### rtl/rip_back.sv
// Back end: radix register, accumulator and literal status tracking.
module rip_back #(
    parameter int VALUE_BITS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_data,
    input  logic             i_tok_empty,
    input  rip_pkg::t_token  i_token,
    output logic             o_tok_pop,
    input  logic             i_res_full,
    output logic             o_res_push,
    output rip_pkg::t_result o_result
);

    rip_pkg::t_radix  r_radix;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic             r_at_start, n_at_start;
    logic             r_seen, n_seen;
    rip_pkg::t_status r_err, n_err;
    rip_pkg::t_status status;
    logic [VALUE_BITS-1:0] scaled;
    logic [4:0]       radix_value;
    logic             go;

    assign go         = !i_tok_empty && !i_res_full;
    assign o_tok_pop  = go;
    assign o_res_push = go && i_token.is_last;

    always_comb begin
        unique case (r_radix)
            rip_pkg::RADIX_BIN: begin
                radix_value = 5'd2;
                scaled      = r_acc << 1;
            end
            rip_pkg::RADIX_OCT: begin
                radix_value = 5'd8;
                scaled      = r_acc << 3;
            end
            rip_pkg::RADIX_DEC: begin
                radix_value = 5'd10;
                scaled      = (r_acc << 3) + (r_acc << 1);
            end
            rip_pkg::RADIX_HEX: begin
                radix_value = 5'd16;
                scaled      = r_acc << 4;
            end
            default: begin
                radix_value = 5'd16;
                scaled      = r_acc << 4;
            end
        endcase
    end

    always_comb begin
        n_acc      = r_acc;
        n_at_start = r_at_start;
        n_seen     = r_seen;
        n_err      = r_err;
        if (r_at_start) begin
            n_at_start = 1'b0;
            if (!i_token.is_hash) begin
                n_err = rip_pkg::ST_NO_PREFIX;
            end
        end else if (r_err == rip_pkg::ST_OK) begin
            if (i_token.digit >= radix_value) begin
                n_err = rip_pkg::ST_BAD_DIGIT;
            end else begin
                n_acc  = scaled + VALUE_BITS'(i_token.digit[3:0]);
                n_seen = 1'b1;
            end
        end

        if (n_err == rip_pkg::ST_OK && !n_seen) begin
            status = rip_pkg::ST_NO_DIGITS;
        end else begin
            status = n_err;
        end
        o_result.status       = status;
        o_result.parsed_value = (status == rip_pkg::ST_OK) ? 64'(n_acc) : 64'd0;

        if (i_token.is_last) begin
            n_acc      = '0;
            n_at_start = 1'b1;
            n_seen     = 1'b0;
            n_err      = rip_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix    <= rip_pkg::RADIX_DEC;
            r_acc      <= '0;
            r_at_start <= 1'b1;
            r_seen     <= 1'b0;
            r_err      <= rip_pkg::ST_OK;
        end else begin
            if (i_cfg_we) begin
                r_radix <= rip_pkg::t_radix'(i_cfg_data);
            end
            if (go) begin
                r_acc      <= n_acc;
                r_at_start <= n_at_start;
                r_seen     <= n_seen;
                r_err      <= n_err;
            end
        end
    end

endmodule

### rtl/radix_integer_parser.sv
// Top level of the radix integer parser: front end, token queue, back end, result queue.
//
//   channel   direction  handshake          payload
//   char in   input      push / full        i_item (char_code, is_last)
//   result    output     empty / pop        o_result (parsed_value, status)
//   config    input      i_cfg_we           i_cfg_data (radix_select)
//
// One character per cycle while full is low; the back end's shift-add accumulator update sets this rate.
// A result goes from the token queue through the back end into the result queue, then can be popped;
// the back end holds the last token while the result queue is full.
// Reset is synchronous; both queues empty and radix returns to decimal.
// A stalled result side fills the result queue, then the token queue, then raises full.
module radix_integer_parser #(
    parameter int VALUE_BITS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    input  rip_pkg::t_char_item i_item,
    output logic                full,
    output logic                empty,
    input  logic                pop,
    output rip_pkg::t_result    o_result,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_data
);

    logic             tok_push, tok_full, tok_pop, tok_empty;
    rip_pkg::t_token  tok_in, tok_out;
    logic             res_push, res_full;
    rip_pkg::t_result res_in;

    assign full = tok_full;

    rip_front u_front (
        .i_push     (push),
        .i_item     (i_item),
        .i_tok_full (tok_full),
        .o_tok_push (tok_push),
        .o_token    (tok_in)
    );

    rip_fifo #(
        .WIDTH     ($bits(rip_pkg::t_token)),
        .ADDR_BITS (1)
    ) u_tok_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (tok_push),
        .i_data  (tok_in),
        .o_full  (tok_full),
        .i_pop   (tok_pop),
        .o_data  (tok_out),
        .o_empty (tok_empty)
    );

    rip_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_tok_empty (tok_empty),
        .i_token     (tok_out),
        .o_tok_pop   (tok_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_result    (res_in)
    );

    rip_fifo #(
        .WIDTH     ($bits(rip_pkg::t_result)),
        .ADDR_BITS (1)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule
